/* rtl/lrast_pkg.sv */
// shared types and constants of the line rasterizer
// no dependencies; imported by every other rtl file
package lrast_pkg;

  localparam int unsigned XW    = 9;   // column width
  localparam int unsigned YW    = 8;   // row width
  localparam int unsigned CW    = 16;  // color width
  localparam int unsigned AW    = 32;  // address width
  localparam int unsigned DXW   = XW + 1;
  localparam int unsigned DYW   = YW + 1;
  localparam int unsigned STW   = DXW;
  localparam int unsigned MAGW  = XW;
  localparam int unsigned PRODW = 2 * MAGW;
  localparam int unsigned ROW_SHIFT = 10;
  localparam int unsigned COL_SHIFT = 1;

  // quotient never exceeds the step magnitude, so it fits in MAGW bits
  localparam int unsigned DIV_STEPS = MAGW;
  localparam int unsigned CNTW      = $clog2(DIV_STEPS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } lrast_state_e;

  typedef struct packed {
    logic load_line;
    logic mul_load;
    logic div_step;
    logic out_write;
    logic out_null;
  } lrast_ctrl_t;

  typedef struct packed {
    logic line_active;
    logic out_free;
  } lrast_stat_t;

endpackage

/* rtl/lrast_if.sv */
// valid/ready channel interfaces for command and pixel words
// depends on lrast_pkg
interface lrast_cmd_if import lrast_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          command;
  logic [XW-1:0] start_x;
  logic [YW-1:0] start_y;
  logic [XW-1:0] end_x;
  logic [YW-1:0] end_y;
  logic [CW-1:0] line_colour;

  modport source (output valid, command, start_x, start_y, end_x, end_y, line_colour,
                  input ready);
  modport sink (input valid, command, start_x, start_y, end_x, end_y, line_colour,
                output ready);
endinterface

interface lrast_pix_if import lrast_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          pixel_valid;
  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic [CW-1:0] pixel_colour;
  logic [AW-1:0] pixel_address;
  logic          last_pixel;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_colour, pixel_address,
                  last_pixel, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_colour, pixel_address,
                last_pixel, output ready);
endinterface

/* rtl/line_rasterizer_core.sv */
// line rasterizer top level: controller plus datapath
// depends on lrast_pkg, lrast_if, lrast_ctrl, lrast_dp
//
// usage:
//   cmd_i takes command words. a load word (command 0) latches both endpoints
//   and the color and gives no pixel word. a next word (command 1) gives one
//   pixel word on pix_o, walking the line from its lower major coordinate to
//   its higher one; last_pixel marks the final pixel, after which the line is
//   inactive. a next word with no active line gives a word with pixel_valid 0.
//   the user must write frame_base through cfg_we_i/cfg_wdata_i only while the
//   block is idle; the block itself does not enforce this. a load word is taken
//   in idle and leaves the controller idle. a next word on an active line passes
//   the multiply state, the divider steps (one quotient bit each) and the done
//   state, whose output write puts its pixel word in the output register. a next
//   word with no active line goes straight to done. no command word is taken
//   until the done state has written the output word.
// reset and stall:
//   reset clears the active line, output valid flag and frame_base. the result
//   sits in an output register, so a new command word is taken while a pixel
//   word waits; a finished pixel holds in the datapath until the register frees.
module line_rasterizer_core import lrast_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [AW-1:0] cfg_wdata_i,
  lrast_cmd_if.sink     cmd_i,
  lrast_pix_if.source   pix_o
);

  lrast_ctrl_t ctrl;
  lrast_stat_t stat;

  lrast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .command_i   (cmd_i.command),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  lrast_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_x_i       (cmd_i.start_x),
    .start_y_i       (cmd_i.start_y),
    .end_x_i         (cmd_i.end_x),
    .end_y_i         (cmd_i.end_y),
    .line_colour_i   (cmd_i.line_colour),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_ready_i     (pix_o.ready),
    .out_valid_o     (pix_o.valid),
    .pixel_valid_o   (pix_o.pixel_valid),
    .pixel_x_o       (pix_o.pixel_x),
    .pixel_y_o       (pix_o.pixel_y),
    .pixel_colour_o  (pix_o.pixel_colour),
    .pixel_address_o (pix_o.pixel_address),
    .last_pixel_o    (pix_o.last_pixel)
  );

endmodule

/* rtl/lrast_ctrl.sv */
// controller state machine: sequences load, multiply, divide and output write
// depends on lrast_pkg
module lrast_ctrl import lrast_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        command_i,
  output logic        cmd_ready_o,
  input  lrast_stat_t stat_i,
  output lrast_ctrl_t ctrl_o
);

  lrast_state_e    state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            null_q, null_d;

  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    null_d  = null_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (command_i == CMD_LOAD) begin
            ctrl_o.load_line = 1'b1;
          end else if (!stat_i.line_active) begin
            null_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            null_d  = 1'b0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        ctrl_o.mul_load = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (stat_i.out_free) begin
          ctrl_o.out_write = 1'b1;
          ctrl_o.out_null  = null_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      null_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      null_q  <= null_d;
    end
  end

endmodule

/* rtl/lrast_dp.sv */
// datapath: line state, magnitude multiplier, restoring divider, output register
// depends on lrast_pkg; driven by lrast_ctrl
module lrast_dp import lrast_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [AW-1:0] cfg_wdata_i,
  input  logic [XW-1:0] start_x_i,
  input  logic [YW-1:0] start_y_i,
  input  logic [XW-1:0] end_x_i,
  input  logic [YW-1:0] end_y_i,
  input  logic [CW-1:0] line_colour_i,
  input  lrast_ctrl_t   ctrl_i,
  output lrast_stat_t   stat_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          pixel_valid_o,
  output logic [XW-1:0] pixel_x_o,
  output logic [YW-1:0] pixel_y_o,
  output logic [CW-1:0] pixel_colour_o,
  output logic [AW-1:0] pixel_address_o,
  output logic          last_pixel_o
);

  function automatic logic [MAGW-1:0] mag(input logic [DXW-1:0] v);
    logic [DXW-1:0] n;
    n = ~v + 1'b1;
    return v[DXW-1] ? n[MAGW-1:0] : v[MAGW-1:0];
  endfunction

  // line state
  logic                  active_q;
  logic [XW-1:0]         orig_x_q;
  logic [YW-1:0]         orig_y_q;
  logic signed [DXW-1:0] dx_q;
  logic signed [DYW-1:0] dy_q;
  logic                  xmaj_q;
  logic signed [STW-1:0] step_q;
  logic [CW-1:0]         colour_q;
  logic [AW-1:0]         base_q;

  // divider
  logic [MAGW-1:0] rem_q, quo_q, dsor_q;
  logic            neg_q;

  // output register
  logic          ov_q, opv_q, olast_q;
  logic [XW-1:0] ox_q;
  logic [YW-1:0] oy_q;
  logic [CW-1:0] oc_q;
  logic [AW-1:0] oa_q;

  // load decode
  logic signed [DXW-1:0] ld_dx, ld_major;
  logic signed [DYW-1:0] ld_dy;
  logic [MAGW-1:0]       ld_adx, ld_ady;
  logic                  ld_xmaj;

  assign ld_dx   = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign ld_dy   = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign ld_adx  = mag(ld_dx);
  assign ld_ady  = mag({ld_dy[DYW-1], ld_dy});
  assign ld_xmaj = ld_adx >= ld_ady;
  assign ld_major = ld_xmaj ? ld_dx : {ld_dy[DYW-1], ld_dy};

  // per-pixel operands
  logic signed [DXW-1:0] major, minor, end_i, q_s, off;
  logic [PRODW-1:0]      prod;
  logic [MAGW:0]         trial, diff;
  logic                  ge, last;
  logic [DXW-1:0]        sum_x, sum_y;
  logic [XW-1:0]         px;
  logic [YW-1:0]         py;

  assign major = xmaj_q ? dx_q : {dy_q[DYW-1], dy_q};
  assign minor = xmaj_q ? {dy_q[DYW-1], dy_q} : dx_q;
  assign prod  = PRODW'(mag(minor)) * PRODW'(mag(step_q));

  assign trial = {rem_q, quo_q[MAGW-1]};
  assign ge    = trial >= {1'b0, dsor_q};
  assign diff  = trial - {1'b0, dsor_q};

  // zero divisor only when both deltas are zero: offset is zero
  assign q_s   = (dsor_q == '0) ? '0 : $signed({1'b0, quo_q});
  assign off   = neg_q ? -q_s : q_s;
  assign sum_x = {1'b0, orig_x_q} + (xmaj_q ? step_q : off);
  assign sum_y = {2'b0, orig_y_q} + (xmaj_q ? off : step_q);
  assign px    = sum_x[XW-1:0];
  assign py    = sum_y[YW-1:0];
  assign end_i = (major > 0) ? major : '0;
  assign last  = step_q >= end_i;

  assign stat_o.line_active = active_q;
  assign stat_o.out_free    = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
      base_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (ctrl_i.load_line) begin
        active_q <= 1'b1;
      end else if (ctrl_i.out_write && !ctrl_i.out_null && last) begin
        active_q <= 1'b0;
      end
      if (ctrl_i.out_write) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_line) begin
      orig_x_q <= start_x_i;
      orig_y_q <= start_y_i;
      dx_q     <= ld_dx;
      dy_q     <= ld_dy;
      xmaj_q   <= ld_xmaj;
      colour_q <= line_colour_i;
      step_q   <= ld_major[DXW-1] ? ld_major : '0;
    end else if (ctrl_i.out_write && !ctrl_i.out_null && !last) begin
      step_q <= step_q + 1'b1;
    end
    if (ctrl_i.mul_load) begin
      // product < divisor * 2^MAGW, so the upper half is already a valid remainder
      rem_q  <= prod[PRODW-1:MAGW];
      quo_q  <= prod[MAGW-1:0];
      dsor_q <= mag(major);
      neg_q  <= major[DXW-1] ^ minor[DXW-1] ^ step_q[STW-1];
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? diff[MAGW-1:0] : trial[MAGW-1:0];
      quo_q <= {quo_q[MAGW-2:0], ge};
    end
    if (ctrl_i.out_write) begin
      if (ctrl_i.out_null) begin
        opv_q   <= 1'b0;
        ox_q    <= '0;
        oy_q    <= '0;
        oc_q    <= '0;
        oa_q    <= '0;
        olast_q <= 1'b0;
      end else begin
        opv_q   <= 1'b1;
        ox_q    <= px;
        oy_q    <= py;
        oc_q    <= colour_q;
        oa_q    <= base_q + (AW'(py) << ROW_SHIFT) + (AW'(px) << COL_SHIFT);
        olast_q <= last;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign pixel_valid_o   = opv_q;
  assign pixel_x_o       = ox_q;
  assign pixel_y_o       = oy_q;
  assign pixel_colour_o  = oc_q;
  assign pixel_address_o = oa_q;
  assign last_pixel_o    = olast_q;

endmodule
